// ===== design/page_split_dma_command_generator_core_assert.svh =====
// assertion macros used by the command generator back end
`ifndef PAGE_SPLIT_DMA_COMMAND_GENERATOR_CORE_ASSERT_SVH
`define PAGE_SPLIT_DMA_COMMAND_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("psd assertion failed");

// next-cycle implication, checked outside reset
`define PSD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("psd assertion failed");

`endif

// ===== design/psd_pkg.sv =====
// types and constants of the page-split dma command generator
`timescale 1ns / 1ps
package psd_pkg;

    localparam int MAX_LEN_LOG2 = 20;
    localparam int PAGE_BITS    = 12;
    localparam int CHUNK_LSB    = 34;
    localparam int SRC_LAST_BIT = 55;
    localparam int ATTR_LSB     = 56;
    localparam logic [12:0] PAGE_BYTES = 13'd4096;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_OP    = 2'd1;
    localparam logic [1:0] ST_BAD_GEOM  = 2'd2;
    localparam logic [1:0] ST_BAD_FRAME = 2'd3;

    localparam logic [1:0] Q_SRC    = 2'd0;
    localparam logic [1:0] Q_DST    = 2'd1;
    localparam logic [1:0] Q_STATUS = 2'd2;

    localparam logic [1:0] WANT_NONE = 2'd0;
    localparam logic [1:0] WANT_SRC  = 2'd1;
    localparam logic [1:0] WANT_DST  = 2'd2;

    localparam logic MODE_REQUEST = 1'b0;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_SRC1 = 5'b00010,
        PH_DST1 = 5'b00100,
        PH_SRCR = 5'b01000,
        PH_DSTR = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        mode;
        logic [38:0] src_addr;
        logic [38:0] dst_addr;
        logic [20:0] req_length;
        logic [2:0]  op_code;
        logic [7:0]  attribute;
        logic [21:0] frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  target_queue;
        logic [63:0] command;
        logic [1:0]  status;
        logic [8:0]  src_pages;
        logic [9:0]  dst_pages;
        logic        op_done;
        logic [1:0]  next_wanted;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic        mode;
        logic [1:0]  status;
        logic [8:0]  src_total;
        logic [9:0]  dst_total;
        logic [11:0] src_offset;
        logic [11:0] dst_offset;
        logic [20:0] src_len;
        logic [21:0] dst_len;
        logic [12:0] src_tail;
        logic [12:0] dst_tail;
        logic [2:0]  op_code;
        logic [7:0]  attribute;
        logic [21:0] frame;
    } rec_t;

endpackage

// ===== design/psd_stream_if.sv =====
// valid/ready channel carrying one payload per transfer
`timescale 1ns / 1ps
interface psd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/psd_front.sv =====
// front: validates requests and works out page geometry
`timescale 1ns / 1ps
module psd_front (
    input  psd_pkg::in_item_t item,
    output psd_pkg::rec_t     rec
);
    import psd_pkg::*;

    logic [21:0] dlen;
    logic [39:0] src_end;
    logic [39:0] dst_end;
    logic [27:0] src_span;
    logic [27:0] dst_span;
    logic [31:0] len_limit;
    logic        geom_bad;

    always_comb
    begin
        // destination length from opcode chaining
        dlen = {1'b0, item.req_length};
        if (item.op_code == 3'd1)
        begin
            if (item.attribute[0] && item.attribute[1])
                dlen = {1'b0, item.req_length};
            else
                dlen = {item.req_length, 1'b0};
        end
        else if (item.op_code == 3'd2)
        begin
            if (item.attribute[0])
                dlen = {2'b0, item.req_length[20:1]};
        end
        else if (item.op_code == 3'd3)
        begin
            dlen = {2'b0, item.req_length[20:1]};
        end
    end

    assign src_end  = {1'b0, item.src_addr} + {19'b0, item.req_length} - 40'd1;
    assign dst_end  = {1'b0, item.dst_addr} + {18'b0, dlen} - 40'd1;
    assign src_span = src_end[39:PAGE_BITS] - {1'b0, item.src_addr[38:PAGE_BITS]};
    assign dst_span = dst_end[39:PAGE_BITS] - {1'b0, item.dst_addr[38:PAGE_BITS]};
    assign len_limit = 32'd1 << MAX_LEN_LOG2;

    assign geom_bad = (item.src_addr[5:0] != 6'd0) || (item.dst_addr[5:0] != 6'd0)
                   || (item.req_length[5:0] != 6'd0) || (dlen[5:0] != 6'd0)
                   || (item.req_length == 21'd0)
                   || ({11'b0, item.req_length} > len_limit);

    always_comb
    begin
        rec.mode       = item.mode;
        rec.status     = (item.op_code > 3'd3) ? ST_BAD_OP : (geom_bad ? ST_BAD_GEOM : ST_OK);
        rec.src_total  = src_span[8:0] + 9'd1;
        rec.dst_total  = dst_span[9:0] + 10'd1;
        rec.src_offset = item.src_addr[11:0];
        rec.dst_offset = item.dst_addr[11:0];
        rec.src_len    = item.req_length;
        rec.dst_len    = dlen;
        rec.src_tail   = {1'b0, src_end[11:0]} + 13'd1;
        rec.dst_tail   = {1'b0, dst_end[11:0]} + 13'd1;
        rec.op_code    = item.op_code;
        rec.attribute  = item.attribute;
        rec.frame      = item.frame;
    end
endmodule

// ===== design/psd_queue.sv =====
// two-entry queue between front and back
`timescale 1ns / 1ps
module psd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psd_pkg::rec_t push_data,
    input  logic          pop,
    output psd_pkg::rec_t pop_data,
    output logic          full,
    output logic          not_empty
);
    import psd_pkg::*;

    rec_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== design/psd_back.sv =====
// back: chunk sequencer building command words into an output register
`timescale 1ns / 1ps
module psd_back #(
    parameter int PHYS_BITS = 34
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  psd_pkg::rec_t      rec,
    output logic               rec_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output psd_pkg::out_item_t out_item
);
    import psd_pkg::*;
`include "page_split_dma_command_generator_core_assert.svh"

    localparam logic [63:0] PHYS_MASK = (64'd1 << PHYS_BITS) - 64'd1;

    phase_t      phase_reg, phase_next;
    logic [8:0]  src_total_reg, src_total_next;
    logic [9:0]  dst_total_reg, dst_total_next;
    logic [8:0]  src_issued_reg, src_issued_next;
    logic [9:0]  dst_issued_reg, dst_issued_next;
    logic [11:0] src_offset_reg, src_offset_next;
    logic [11:0] dst_offset_reg, dst_offset_next;
    logic [20:0] saved_length_reg, saved_length_next;
    logic [21:0] dst_length_reg, dst_length_next;
    logic [12:0] src_tail_reg, src_tail_next;
    logic [12:0] dst_tail_reg, dst_tail_next;
    logic [2:0]  opcode_reg, opcode_next;
    logic [7:0]  attr_reg, attr_next;
    logic        out_valid_reg;
    out_item_t   out_reg, out_next;

    logic [63:0] head;
    logic [63:0] page_addr;
    logic [12:0] src_room, dst_room;
    logic [12:0] chunk;
    logic [8:0]  src_inc;
    logic [9:0]  dst_inc;

    assign rec_pop   = rec_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign head      = {attr_reg, 53'b0, opcode_reg};
    assign page_addr = ({42'b0, rec.frame} << PAGE_BITS);
    assign src_room  = PAGE_BYTES - {1'b0, src_offset_reg};
    assign dst_room  = PAGE_BYTES - {1'b0, dst_offset_reg};
    assign src_inc   = src_issued_reg + 9'd1;
    assign dst_inc   = dst_issued_reg + 10'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        src_total_next    = src_total_reg;
        dst_total_next    = dst_total_reg;
        src_issued_next   = src_issued_reg;
        dst_issued_next   = dst_issued_reg;
        src_offset_next   = src_offset_reg;
        dst_offset_next   = dst_offset_reg;
        saved_length_next = saved_length_reg;
        dst_length_next   = dst_length_reg;
        src_tail_next     = src_tail_reg;
        dst_tail_next     = dst_tail_reg;
        opcode_next       = opcode_reg;
        attr_next         = attr_reg;
        chunk             = 13'd0;

        out_next.target_queue = Q_STATUS;
        out_next.command      = 64'd0;
        out_next.status       = ST_OK;
        out_next.src_pages    = src_total_reg;
        out_next.dst_pages    = dst_total_reg;
        out_next.op_done      = 1'b0;

        if (rec.mode == MODE_REQUEST)
        begin
            out_next.status = rec.status;
            if (rec.status != ST_OK)
            begin
                out_next.src_pages = 9'd0;
                out_next.dst_pages = 10'd0;
            end
            else
            begin
                // accepted request drops whatever was in flight
                phase_next         = PH_SRC1;
                src_total_next     = rec.src_total;
                dst_total_next     = rec.dst_total;
                src_issued_next    = 9'd0;
                dst_issued_next    = 10'd0;
                src_offset_next    = rec.src_offset;
                dst_offset_next    = rec.dst_offset;
                saved_length_next  = rec.src_len;
                dst_length_next    = rec.dst_len;
                src_tail_next      = rec.src_tail;
                dst_tail_next      = rec.dst_tail;
                opcode_next        = rec.op_code;
                attr_next          = rec.attribute;
                out_next.src_pages = rec.src_total;
                out_next.dst_pages = rec.dst_total;
            end
        end
        else
        begin
            case (phase_reg)
                PH_SRC1:
                begin
                    chunk = ({8'b0, src_room} > saved_length_reg) ? saved_length_reg[12:0]
                                                                  : src_room;
                    out_next.target_queue = Q_SRC;
                    out_next.command = ((page_addr + {52'b0, src_offset_reg}) & PHYS_MASK)
                                     | ({51'b0, chunk} << CHUNK_LSB) | head;
                    out_next.command[SRC_LAST_BIT] = (src_total_reg == 9'd1);
                    src_issued_next = 9'd1;
                    phase_next      = PH_DST1;
                end
                PH_DST1:
                begin
                    chunk = ({9'b0, dst_room} > dst_length_reg) ? dst_length_reg[12:0]
                                                                : dst_room;
                    out_next.target_queue = Q_DST;
                    out_next.command = ((page_addr + {52'b0, dst_offset_reg}) & PHYS_MASK)
                                     | ({51'b0, chunk} << CHUNK_LSB) | head;
                    dst_issued_next = 10'd1;
                    if (src_total_reg > 9'd1)
                        phase_next = PH_SRCR;
                    else if (dst_total_reg > 10'd1)
                        phase_next = PH_DSTR;
                    else
                    begin
                        phase_next       = PH_IDLE;
                        out_next.op_done = 1'b1;
                    end
                end
                PH_SRCR:
                begin
                    src_issued_next = src_inc;
                    out_next.target_queue = Q_SRC;
                    chunk = (src_inc >= src_total_reg) ? src_tail_reg : PAGE_BYTES;
                    out_next.command = (page_addr & PHYS_MASK) | ({51'b0, chunk} << CHUNK_LSB);
                    if (src_inc >= src_total_reg)
                    begin
                        out_next.command[SRC_LAST_BIT] = 1'b1;
                        if (dst_total_reg > 10'd1)
                            phase_next = PH_DSTR;
                        else
                        begin
                            phase_next       = PH_IDLE;
                            out_next.op_done = 1'b1;
                        end
                    end
                end
                PH_DSTR:
                begin
                    dst_issued_next = dst_inc;
                    out_next.target_queue = Q_DST;
                    chunk = (dst_inc >= dst_total_reg) ? dst_tail_reg : PAGE_BYTES;
                    out_next.command = (page_addr & PHYS_MASK) | ({51'b0, chunk} << CHUNK_LSB);
                    if (dst_inc >= dst_total_reg)
                    begin
                        phase_next       = PH_IDLE;
                        out_next.op_done = 1'b1;
                    end
                end
                default:
                begin
                    // frame with no request in flight
                    out_next.status    = ST_BAD_FRAME;
                    out_next.src_pages = 9'd0;
                    out_next.dst_pages = 10'd0;
                end
            endcase
        end

        case (phase_next)
            PH_SRC1, PH_SRCR: out_next.next_wanted = WANT_SRC;
            PH_DST1, PH_DSTR: out_next.next_wanted = WANT_DST;
            default:          out_next.next_wanted = WANT_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            src_total_reg    <= 9'd0;
            dst_total_reg    <= 10'd0;
            src_issued_reg   <= 9'd0;
            dst_issued_reg   <= 10'd0;
            src_offset_reg   <= 12'd0;
            dst_offset_reg   <= 12'd0;
            saved_length_reg <= 21'd0;
            dst_length_reg   <= 22'd0;
            src_tail_reg     <= 13'd0;
            dst_tail_reg     <= 13'd0;
            opcode_reg       <= 3'd0;
            attr_reg         <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (rec_pop)
            begin
                phase_reg        <= phase_next;
                src_total_reg    <= src_total_next;
                dst_total_reg    <= dst_total_next;
                src_issued_reg   <= src_issued_next;
                dst_issued_reg   <= dst_issued_next;
                src_offset_reg   <= src_offset_next;
                dst_offset_reg   <= dst_offset_next;
                saved_length_reg <= saved_length_next;
                dst_length_reg   <= dst_length_next;
                src_tail_reg     <= src_tail_next;
                dst_tail_reg     <= dst_tail_next;
                opcode_reg       <= opcode_next;
                attr_reg         <= attr_next;
            end
            if (rec_pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    `PSD_ASSERT_IMPLY(a_done_is_cmd, clk, rst_n,
        out_valid_reg && out_reg.op_done, out_reg.target_queue != Q_STATUS)
    `PSD_ASSERT_IMPLY(a_err_no_cmd, clk, rst_n,
        out_valid_reg && (out_reg.status != ST_OK), out_reg.command == 64'd0)
    `PSD_ASSERT_NEXT(a_done_goes_idle, clk, rst_n,
        rec_pop && out_next.op_done, phase_reg == PH_IDLE)
endmodule

// ===== design/page_split_dma_command_generator_core.sv =====
// top level: page-split dma command generator
// path: each input transfer is written into the queue, then popped by the back end into
// its output register, from which the result leaves
// throughput: one item per cycle while the output is ready, set by the chunk sequencer in the back end
// a two-entry queue parts front and back, so input transfers continue while a result waits
// reset (rst_n, asynchronous, active low) empties the queue and output register
// and returns the sequencer to idle with all counts and saved fields cleared
`timescale 1ns / 1ps
module page_split_dma_command_generator_core #(
    parameter int PHYS_BITS    = 34
) (
    input logic                clk,
    input logic                rst_n,
    psd_stream_if.sink         in_ch,
    psd_stream_if.source       out_ch
);
    import psd_pkg::*;

    rec_t front_rec;
    rec_t queue_rec;
    logic queue_full;
    logic queue_not_empty;
    logic queue_pop;

    // front: combinational classification of each incoming transfer
    psd_front u_front (
        .item (in_ch.data),
        .rec  (front_rec)
    );

    assign in_ch.ready = !queue_full;

    // short queue so either side may stall on its own
    psd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_ch.valid && !queue_full),
        .push_data (front_rec),
        .pop       (queue_pop),
        .pop_data  (queue_rec),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    // back: sequencer and registered result
    psd_back #(
        .PHYS_BITS (PHYS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (queue_not_empty),
        .rec       (queue_rec),
        .rec_pop   (queue_pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.data)
    );
endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the page-split dma command generator
`timescale 1ns / 1ps
module tb_top;
    import psd_pkg::*;

    localparam int LEN_LOG2    = MAX_LEN_LOG2;
    localparam int ADDR_BITS   = 34;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 550;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    psd_stream_if #(.T(in_item_t))  in_ch();
    psd_stream_if #(.T(out_item_t)) out_ch();

    page_split_dma_command_generator_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // 8 ns clock, high then low
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // items waiting to be offered, and commands expected back in order
    in_item_t  stim_q[$];
    out_item_t expected_cmds[$];

    int  n_accepted = 0;
    int  n_results = 0;
    int  n_frames = 0;
    int  n_rejects = 0;
    int  n_errors = 0;
    int  cycles = 0;
    bit  in_taken = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_cnt = 0;

    // shadow copy of the sequencer state
    phase_t      ph;
    logic [8:0]  s_total, s_issued;
    logic [9:0]  d_total, d_issued;
    logic [11:0] s_off, d_off;
    logic [20:0] s_len;
    logic [21:0] d_len;
    logic [12:0] s_tail, d_tail;
    logic [2:0]  k_op;
    logic [7:0]  k_attr;

    // destination length after opcode doubling, chaining and halving
    function automatic logic [22:0] dst_len_of(logic [2:0] opc, logic [7:0] attr,
                                              logic [20:0] len);
        logic [22:0] l;
        logic [2:0]  o;
        logic [7:0]  a;
        l = {2'b0, len};
        o = opc;
        a = attr;
        if (o == 3'd1)
        begin
            l = l << 1;
            if (a[0])
            begin
                o = 3'd2;
                a = a >> 1;
            end
        end
        if (o == 3'd2 && a[0])
            o = 3'd3;
        if (o == 3'd3)
            l = l >> 1;
        return l;
    endfunction

    // number of 4 KiB pages a buffer touches
    function automatic int page_span(logic [38:0] addr, logic [22:0] len);
        logic [39:0] last;
        last = {1'b0, addr} + len - 1;
        return int'(last[39:PAGE_BITS]) - int'(addr[38:PAGE_BITS]) + 1;
    endfunction

    function automatic logic [63:0] phys_addr(logic [21:0] frame, logic [11:0] off);
        logic [63:0] a;
        a = ({42'b0, frame} << PAGE_BITS) + {52'b0, off};
        return a & ((64'd1 << ADDR_BITS) - 1);
    endfunction

    // works out the result of one transfer and advances the shadow state
    function automatic out_item_t predict_command(in_item_t it);
        out_item_t   r;
        logic [22:0] dl;
        logic [39:0] s_end, d_end;
        logic [12:0] chunk;
        logic [63:0] head;
        r = '0;
        if (it.mode == MODE_REQUEST)
        begin
            r.target_queue = Q_STATUS;
            dl = dst_len_of(it.op_code, it.attribute, it.req_length);
            if (it.op_code > 3'd3)
                r.status = ST_BAD_OP;
            else if (it.src_addr[5:0] != 0 || it.dst_addr[5:0] != 0
                     || it.req_length[5:0] != 0 || dl[5:0] != 0 || it.req_length == 0
                     || it.req_length > (21'd1 << LEN_LOG2))
                r.status = ST_BAD_GEOM;
            else
            begin
                s_end    = {1'b0, it.src_addr} + it.req_length - 1;
                d_end    = {1'b0, it.dst_addr} + dl - 1;
                s_total  = 9'(page_span(it.src_addr, {2'b0, it.req_length}));
                d_total  = 10'(page_span(it.dst_addr, dl));
                s_off    = it.src_addr[11:0];
                d_off    = it.dst_addr[11:0];
                s_tail   = {1'b0, s_end[11:0]} + 13'd1;
                d_tail   = {1'b0, d_end[11:0]} + 13'd1;
                s_len    = it.req_length;
                d_len    = dl[21:0];
                k_op     = it.op_code;
                k_attr   = it.attribute;
                s_issued = '0;
                d_issued = '0;
                ph       = PH_SRC1;
                r.src_pages = s_total;
                r.dst_pages = d_total;
            end
        end
        else if (ph == PH_IDLE)
        begin
            r.target_queue = Q_STATUS;
            r.status = ST_BAD_FRAME;
        end
        else
        begin
            r.src_pages = s_total;
            r.dst_pages = d_total;
            head = {k_attr, 53'b0, k_op};
            case (ph)
                PH_SRC1:
                begin
                    chunk = PAGE_BYTES - s_off;
                    if (chunk > s_len)
                        chunk = s_len[12:0];
                    r.command = phys_addr(it.frame, s_off) | (64'(chunk) << CHUNK_LSB) | head;
                    if (s_total == 1)
                        r.command[SRC_LAST_BIT] = 1'b1;
                    s_issued = 9'd1;
                    r.target_queue = Q_SRC;
                    ph = PH_DST1;
                end
                PH_DST1:
                begin
                    chunk = PAGE_BYTES - d_off;
                    if (chunk > d_len)
                        chunk = d_len[12:0];
                    r.command = phys_addr(it.frame, d_off) | (64'(chunk) << CHUNK_LSB) | head;
                    d_issued = 10'd1;
                    r.target_queue = Q_DST;
                    if (s_total > 1)
                        ph = PH_SRCR;
                    else if (d_total > 1)
                        ph = PH_DSTR;
                    else
                    begin
                        ph = PH_IDLE;
                        r.op_done = 1'b1;
                    end
                end
                PH_SRCR:
                begin
                    s_issued = s_issued + 9'd1;
                    r.command = phys_addr(it.frame, 12'd0);
                    r.target_queue = Q_SRC;
                    if (s_issued >= s_total)
                    begin
                        r.command = r.command | (64'(s_tail) << CHUNK_LSB);
                        r.command[SRC_LAST_BIT] = 1'b1;
                        if (d_total > 1)
                            ph = PH_DSTR;
                        else
                        begin
                            ph = PH_IDLE;
                            r.op_done = 1'b1;
                        end
                    end
                    else
                        r.command = r.command | (64'(PAGE_BYTES) << CHUNK_LSB);
                end
                default:
                begin
                    d_issued = d_issued + 10'd1;
                    r.command = phys_addr(it.frame, 12'd0);
                    r.target_queue = Q_DST;
                    if (d_issued >= d_total)
                    begin
                        r.command = r.command | (64'(d_tail) << CHUNK_LSB);
                        ph = PH_IDLE;
                        r.op_done = 1'b1;
                    end
                    else
                        r.command = r.command | (64'(PAGE_BYTES) << CHUNK_LSB);
                end
            endcase
        end
        if (ph == PH_SRC1 || ph == PH_SRCR)
            r.next_wanted = WANT_SRC;
        else if (ph == PH_DST1 || ph == PH_DSTR)
            r.next_wanted = WANT_DST;
        else
            r.next_wanted = WANT_NONE;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    task automatic push_request(logic [38:0] src, logic [38:0] dst, logic [20:0] len,
                                logic [2:0] opc, logic [7:0] attr);
        in_item_t it;
        it = '0;
        it.mode       = MODE_REQUEST;
        it.src_addr   = src;
        it.dst_addr   = dst;
        it.req_length = len;
        it.op_code    = opc;
        it.attribute  = attr;
        it.frame      = 22'($urandom);
        stim_q.push_back(it);
    endtask

    // a frame transfer; the other fields carry random junk which must be ignored
    task automatic push_frame(logic [21:0] frame);
        in_item_t it;
        it = '0;
        it.src_addr   = 39'({$urandom, $urandom});
        it.dst_addr   = 39'({$urandom, $urandom});
        it.req_length = 21'($urandom);
        it.op_code    = 3'($urandom);
        it.attribute  = 8'($urandom);
        it.mode  = ~MODE_REQUEST;
        it.frame = frame;
        stim_q.push_back(it);
    endtask

    // a well-formed request followed by its frames, less any dropped at the end
    task automatic push_operation(logic [38:0] src, logic [38:0] dst, logic [20:0] len,
                                  logic [2:0] opc, logic [7:0] attr, int drop);
        logic [22:0] dl;
        int          n;
        dl = dst_len_of(opc, attr, len);
        push_request(src, dst, len, opc, attr);
        if (dl[5:0] == 0 && len != 0 && len[5:0] == 0 && src[5:0] == 0 && dst[5:0] == 0)
        begin
            n = page_span(src, {2'b0, len}) + page_span(dst, dl) - drop;
            repeat (n)
                push_frame(22'($urandom));
        end
    endtask

    function automatic logic [38:0] aligned_addr();
        logic [38:0] a;
        a = 39'({$urandom, $urandom});
        a[5:0] = '0;
        return a;
    endfunction

    // ---------------------------------------------------------------
    // driver: offers queued items, idling about a third of the time
    // except in a quiet window where both sides run flat out
    // ---------------------------------------------------------------
    wire quiet_window = (n_accepted >= 150 && n_accepted < 300);

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                in_taken = 1'b0;
                if (stim_q.size() > 0 && (quiet_window || $urandom_range(0, 99) >= 33))
                begin
                    in_ch.data  <= stim_q.pop_front();
                    in_ch.valid <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off so the
    // internal queue fills and the input stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && n_accepted >= 350)
            begin
                hold_done = 1'b1;
                hold_cnt = 300;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt = hold_cnt - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= quiet_window || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: predicts on each input transfer, checks each output one
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                n_results++;
                if (got.target_queue != Q_STATUS)
                    n_frames++;
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    n_errors++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("target_queue", 64'(want.target_queue), 64'(got.target_queue));
                    check_field("command", want.command, got.command);
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("src_pages", 64'(want.src_pages), 64'(got.src_pages));
                    check_field("dst_pages", 64'(want.dst_pages), 64'(got.dst_pages));
                    check_field("op_done", 64'(want.op_done), 64'(got.op_done));
                    check_field("next_wanted", 64'(want.next_wanted), 64'(got.next_wanted));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                want = predict_command(in_ch.data);
                if (want.status == ST_BAD_OP || want.status == ST_BAD_GEOM)
                    n_rejects++;
                expected_cmds.push_back(want);
                in_taken = 1'b1;
                n_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int sel;
        logic [20:0] len;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        ph = PH_IDLE;
        {s_total, s_issued, d_total, d_issued, s_off, d_off} = '0;
        {s_len, d_len, s_tail, d_tail, k_op, k_attr} = '0;

        // directed: stray frame, bad opcodes and broken geometry
        push_frame('1);
        push_request(39'd0, 39'd0, 21'd64, 3'd4, 8'd0);
        push_request('1, '1, '1, 3'd7, 8'hff);
        push_request(39'd32, 39'd0, 21'd64, 3'd0, 8'd0);
        push_request(39'd0, 39'd1, 21'd64, 3'd0, 8'd0);
        push_request(39'd0, 39'd0, 21'd0, 3'd0, 8'd0);
        push_request(39'd0, 39'd0, 21'd100, 3'd0, 8'd0);
        push_request(39'd0, 39'd0, 21'(1 << LEN_LOG2) + 21'd64, 3'd0, 8'd0);
        push_request(39'd0, 39'd0, 21'd64, 3'd3, 8'd0);
        push_request(39'd0, 39'd0, 21'd64, 3'd2, 8'd1);
        // directed: every opcode and chaining path
        push_operation(39'd0, 39'd0, 21'd64, 3'd0, 8'd0, 0);
        push_operation(39'h0fc0, 39'h1f80, 21'd256, 3'd1, 8'd0, 0);
        push_operation(39'd4096, 39'h2040, 21'd8192, 3'd1, 8'd1, 0);
        push_operation(39'h0fc0, 39'h0f00, 21'd4224, 3'd1, 8'd3, 0);
        push_operation(39'h3000, 39'h5000, 21'd4096, 3'd2, 8'd0, 0);
        push_operation(39'h0f80, 39'h0040, 21'd8320, 3'd2, 8'hff, 0);
        push_operation(39'h1000, 39'h7fc0, 21'd512, 3'd3, 8'h80, 0);
        // top of the address space and all-ones frames
        push_request('1 - 39'd63, '1 - 39'd4095, 21'd4096, 3'd0, 8'hff);
        push_frame('1);
        push_frame('1);
        push_frame('1);
        // longest length, abandoned by a fresh request
        push_operation(39'h40, 39'h40, 21'(1 << LEN_LOG2), 3'd0, 8'h5a, 512);
        // rejected request in the middle of an operation leaves it running
        push_request(39'h2000, 39'h3000, 21'd8192, 3'd0, 8'h11);
        push_frame(22'h155555);
        push_request(39'd0, 39'd0, 21'd64, 3'd6, 8'd0);
        repeat (3)
            push_frame(22'h2aaaaa);

        // random: mostly complete operations, some noise
        while (stim_q.size() < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
            begin
                if ($urandom_range(0, 19) == 0)
                    len = 21'(64 * $urandom_range(1, 1024));
                else
                    len = 21'(64 * $urandom_range(1, 160));
                push_operation(aligned_addr(), aligned_addr(), len,
                               3'($urandom_range(0, 3)), 8'($urandom),
                               ($urandom_range(0, 9) == 0) ? 1 : 0);
            end
            else if (sel < 88)
                push_request(39'({$urandom, $urandom}), 39'({$urandom, $urandom}),
                             21'($urandom), 3'($urandom), 8'($urandom));
            else
                push_frame(22'($urandom));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (stim_q.size() == 0 && !in_ch.valid && expected_cmds.size() == 0);
        repeat (20) @(posedge clk);

        $display("%0d transfers in, %0d results out (%0d page commands, %0d rejected requests)",
                 n_accepted, n_results, n_frames, n_rejects);
        $display("%0d mismatches, %0d results still outstanding", n_errors, expected_cmds.size());
        if (n_errors == 0 && expected_cmds.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
